/* rtl/core/assert_macros.svh */
// Assertion macros shared by the core RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational invariant, sampled on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Same-cycle implication, sampled on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bds_pkg.sv */
// Shared constants, types and helpers of the 2x2 box downsampler.
// No dependencies; used by the core top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SUM_W      = PIX_W + 1;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1
    } cfg_reg_t;

    // Zero reads as one, oversize saturates to the limit.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bds_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/box_downsample_2x2_u8_core.sv */
// 2x2 box-filter mip level reduction for 8-bit pixels, top level.
// Depends on bds_pkg, bds_ram and assert_macros.svh.
//
// Usage:
//  - s_ channel: source pixels in raster order, valid/ready. One pixel per
//    cycle is taken in steady state while the receiver does not stall.
//  - m_ channel: destination pixels, valid/ready, with m_last_of_frame on the
//    final pixel of the destination image.
//  - cfg port: cfg_wr_en/cfg_index/cfg_wr_data, index 0 = source width,
//    1 = source height. Zero reads as 1, oversize saturates to 4096. A write
//    to either register restarts the frame. Write only while idle.
//  - Throughput: 1 item per cycle while the receiver does not stall.
//    Latency: a result shows on m_ the cycle after the item that completes
//    its block (odd column of an odd row, or odd pixel of a pair) is taken.
//  - Horizontal pair sums of even rows sit in a 2048 x 9 line RAM (one
//    write port, one registered read port). The read for a 2x2 block is
//    issued on its even-column pixel, so the sum is ready for the odd one.
//  - Receiver stall: the single output register holds its item; input items
//    that complete no block are still taken, others wait.
//  - Reset: size registers go to 1, counters to 0; the line RAM is not
//    cleared (every entry is written in an even row before it is read).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module box_downsample_2x2_u8_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // config write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [bds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bds_pkg::SIZE_W-1:0]       cfg_wr_data,
    // source pixels
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [bds_pkg::PIX_W-1:0]        s_pixel_value,
    // destination pixels
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [bds_pkg::PIX_W-1:0]        m_average_value,
    output logic                                  m_last_of_frame
);

    localparam int SIZE_W = bds_pkg::SIZE_W;
    localparam int COL_W  = bds_pkg::COL_W;
    localparam int ROW_W  = bds_pkg::ROW_W;
    localparam int PIX_W  = bds_pkg::PIX_W;
    localparam int SUM_W  = bds_pkg::SUM_W;
    localparam int AW     = bds_pkg::LINE_AW;
    localparam logic [SIZE_W-1:0] MAX_W = SIZE_W'(bds_pkg::MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(bds_pkg::MAX_HEIGHT);

    // clamped frame size
    logic [SIZE_W-1:0] width_reg, height_reg;
    // raster position of the next pixel, and the held even pixel
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [PIX_W-1:0]  held_reg;
    // output register
    logic              m_valid_reg;
    logic [PIX_W-1:0]  avg_reg;
    logic              last_reg;

    // per-position decode (flags from state only, independent of payload) and the average
    logic [SIZE_W-2:0] dst_w, dst_h;
    logic              col_in, row_in, odd_c, odd_r;
    logic              hold_now, wr_now, rd_now, emit_now, last_now;
    logic [PIX_W-1:0]  avg_now;
    logic              col_wrap, row_wrap;
    logic              accept;

    // line RAM
    logic [SUM_W-1:0]  line_rd_data;
    logic [SUM_W-1:0]  pair_sum;
    logic [SUM_W:0]    quad_sum;
    logic [AW-1:0]     line_addr;
    logic              ram_wr_en, ram_rd_en;

    assign dst_w  = width_reg[SIZE_W-1:1];
    assign dst_h  = height_reg[SIZE_W-1:1];
    assign odd_c  = col_reg[0];
    assign odd_r  = row_reg[0];
    assign col_in = {1'b0, col_reg} < {dst_w, 1'b0};
    assign row_in = {1'b0, row_reg} < {dst_h, 1'b0};

    assign line_addr = col_reg[COL_W-1:1];
    assign pair_sum  = {1'b0, held_reg} + {1'b0, s_pixel_value};
    assign quad_sum  = {1'b0, line_rd_data} + {1'b0, pair_sum};

    always_comb begin
        hold_now = 1'b0;
        wr_now   = 1'b0;
        rd_now   = 1'b0;
        emit_now = 1'b0;
        last_now = 1'b0;
        avg_now  = pair_sum[SUM_W-1:1];
        if (dst_w != '0 && dst_h != '0) begin
            if (col_in && row_in) begin
                if (!odd_c) begin
                    hold_now = 1'b1;
                    // fetch the even-row pair sum ahead of the odd column
                    rd_now   = odd_r;
                end else if (!odd_r) begin
                    wr_now   = 1'b1;
                end else begin
                    emit_now = 1'b1;
                    avg_now  = quad_sum[SUM_W:2];
                    last_now = ({1'b0, col_reg[COL_W-1:1]} == dst_w - 1'b1) &&
                               ({1'b0, row_reg[ROW_W-1:1]} == dst_h - 1'b1);
                end
            end
        end else if (dst_h != '0) begin
            // one column: vertical pairs
            if (row_in) begin
                hold_now = !odd_r;
                emit_now = odd_r;
                last_now = {1'b0, row_reg[ROW_W-1:1]} == dst_h - 1'b1;
            end
        end else if (dst_w != '0) begin
            // one row: horizontal pairs
            if (col_in) begin
                hold_now = !odd_c;
                emit_now = odd_c;
                last_now = {1'b0, col_reg[COL_W-1:1]} == dst_w - 1'b1;
            end
        end
    end

    // an item that completes no block never waits on the output
    assign s_ready = !m_valid_reg || m_ready || !emit_now;
    assign accept  = s_valid && s_ready;

    assign ram_wr_en = accept && wr_now;
    assign ram_rd_en = accept && rd_now;

    assign col_wrap = ({1'b0, col_reg} + SIZE_W'(1)) >= width_reg;
    assign row_wrap = ({1'b0, row_reg} + SIZE_W'(1)) >= height_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
        end
    end

    bds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (bds_pkg::LINE_DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (line_addr),
        .wr_data (pair_sum),
        .rd_en   (ram_rd_en),
        .rd_addr (line_addr),
        .rd_data (line_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= SIZE_W'(1);
            height_reg  <= SIZE_W'(1);
            col_reg     <= '0;
            row_reg     <= '0;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bds_pkg::REG_SOURCE_WIDTH: begin
                        width_reg <= bds_pkg::clamp_size(cfg_wr_data, MAX_W);
                        col_reg   <= '0;
                        row_reg   <= '0;
                        held_reg  <= '0;
                    end
                    bds_pkg::REG_SOURCE_HEIGHT: begin
                        height_reg <= bds_pkg::clamp_size(cfg_wr_data, MAX_H);
                        col_reg    <= '0;
                        row_reg    <= '0;
                        held_reg   <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (hold_now) begin
                    held_reg <= s_pixel_value;
                end
            end

            if (accept && emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the output register
    always_ff @(posedge aclk) begin
        if (accept && emit_now) begin
            avg_reg  <= avg_now;
            last_reg <= last_now;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_average_value = avg_reg;
    assign m_last_of_frame = last_reg;

    // checks
    `ASSERT_ALWAYS(a_ram_one_port, aclk, aresetn, !(ram_wr_en && ram_rd_en), "line RAM read and write together")
    `ASSERT_ALWAYS(a_pos_in_frame, aclk, aresetn, ({1'b0, col_reg} < width_reg) && ({1'b0, row_reg} < height_reg), "position outside frame")
    `ASSERT_IMPLY(a_emit_on_odd, aclk, aresetn, emit_now, odd_c || odd_r, "result on an even position")
    `ASSERT_IMPLY(a_no_overwrite, aclk, aresetn, accept && m_valid_reg && !m_ready, !emit_now, "output overwritten while stalled")

endmodule

`default_nettype wire

/* dv/box_downsample_2x2_u8_core_checker.sv */
// Scoreboard for the 2x2 box downsampler: tracks config writes and source
// items, predicts each destination pixel and compares it with the m_ channel.
// Depends on bds_pkg.
`timescale 1ns / 1ps

module box_downsample_2x2_u8_core_checker
    import bds_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_wr_data,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic [PIX_W-1:0]     s_pixel_value,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [PIX_W-1:0]     m_average_value,
    input  wire logic                 m_last_of_frame,
    output int                        error_count,
    output int                        outstanding
);

    typedef struct packed {
        logic [PIX_W-1:0] average;
        logic             last;
    } mip_pixel_t;

    mip_pixel_t       mip_pixels_due[$];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [SUM_W-1:0]  pair_sums [0:LINE_DEPTH-1];
    logic [PIX_W-1:0]  held_pix;
    int                col_pos;
    int                row_pos;
    int                mismatches = 0;

    function automatic int eff_size(input logic [SIZE_W-1:0] v, input int limit);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > limit) begin
            return limit;
        end
        return int'(v);
    endfunction

    // One source pixel: update the running state, queue a destination pixel
    // when this one completes a block or pair.
    task automatic predict_average(input logic [PIX_W-1:0] pix);
        int         w;
        int         h;
        int         dw;
        int         dh;
        int         c;
        int         r;
        int         k;
        int         total;
        logic       odd_c;
        logic       odd_r;
        logic       emit;
        logic       last;
        mip_pixel_t item;
        w     = eff_size(width_reg, MAX_WIDTH);
        h     = eff_size(height_reg, MAX_HEIGHT);
        dw    = w >> 1;
        dh    = h >> 1;
        c     = col_pos;
        r     = row_pos;
        odd_c = (c % 2) == 1;
        odd_r = (r % 2) == 1;
        emit  = 1'b0;
        last  = 1'b0;
        total = 0;
        if (dw > 0 && dh > 0) begin
            if (c < 2 * dw && r < 2 * dh) begin
                k = (c >> 1) % LINE_DEPTH;
                if (!odd_c) begin
                    held_pix = pix;
                end else if (!odd_r) begin
                    pair_sums[k] = SUM_W'(int'(held_pix) + int'(pix));
                end else begin
                    total = (int'(pair_sums[k]) + int'(held_pix) + int'(pix)) >> 2;
                    emit  = 1'b1;
                    last  = ((c >> 1) == dw - 1) && ((r >> 1) == dh - 1);
                end
            end
        end else if (dh > 0) begin
            if (r < 2 * dh) begin
                if (!odd_r) begin
                    held_pix = pix;
                end else begin
                    total = (int'(held_pix) + int'(pix)) >> 1;
                    emit  = 1'b1;
                    last  = (r >> 1) == dh - 1;
                end
            end
        end else if (dw > 0) begin
            if (c < 2 * dw) begin
                if (!odd_c) begin
                    held_pix = pix;
                end else begin
                    total = (int'(held_pix) + int'(pix)) >> 1;
                    emit  = 1'b1;
                    last  = (c >> 1) == dw - 1;
                end
            end
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
        if (emit) begin
            item.average = PIX_W'(total);
            item.last    = last;
            mip_pixels_due.push_back(item);
        end
    endtask

    task automatic report_mismatch(input string what, input mip_pixel_t want);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: want avg %0d last %0b, got avg %0d last %0b", $time, what,
                     want.average, want.last, m_average_value, m_last_of_frame);
        end
    endtask

    always @(posedge aclk) begin
        mip_pixel_t want;
        if (!aresetn) begin
            width_reg  = SIZE_W'(1);
            height_reg = SIZE_W'(1);
            held_pix   = '0;
            col_pos    = 0;
            row_pos    = 0;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                pair_sums[i] = '0;
            end
            mip_pixels_due.delete();
        end else begin
            // results leave only after their item is taken, so retire before predicting
            if (m_valid && m_ready) begin
                if (mip_pixels_due.size() == 0) begin
                    want = '0;
                    report_mismatch("result with nothing due", want);
                end else begin
                    want = mip_pixels_due.pop_front();
                    if (m_average_value !== want.average
                            || m_last_of_frame !== want.last) begin
                        report_mismatch("wrong result", want);
                    end
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_SOURCE_WIDTH || cfg_index == REG_SOURCE_HEIGHT) begin
                    if (cfg_index == REG_SOURCE_WIDTH) begin
                        width_reg = cfg_wr_data;
                    end else begin
                        height_reg = cfg_wr_data;
                    end
                    held_pix = '0;
                    col_pos  = 0;
                    row_pos  = 0;
                end
            end
            if (s_valid && s_ready) begin
                predict_average(s_pixel_value);
            end
        end
        error_count <= mismatches;
        outstanding <= mip_pixels_due.size();
    end

endmodule

/* dv/box_downsample_2x2_u8_core_test.sv */
// Top of the 2x2 box downsampler testbench: clock, reset, stimulus and verdict.
// Depends on bds_pkg, the core RTL and box_downsample_2x2_u8_core_checker.
`timescale 1ns / 1ps

module box_downsample_2x2_u8_core_test;
    import bds_pkg::*;

    // indexes with no register behind them: a write must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int RANDOM_ITEMS = 750;
    // cycles without any item moving before the run is called hung
    localparam int STALL_LIMIT  = 5000;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = '0;
    logic [SIZE_W-1:0]    cfg_wr_data     = '0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel_value   = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [PIX_W-1:0]     m_average_value;
    logic                 m_last_of_frame;
    int                   error_count;
    int                   outstanding;
    int                   idle_cycles     = 0;
    int                   ready_hold      = 0;

    always #5 aclk = ~aclk;

    box_downsample_2x2_u8_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_value   (s_pixel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_average_value (m_average_value),
        .m_last_of_frame (m_last_of_frame)
    );

    box_downsample_2x2_u8_core_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_value   (s_pixel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_average_value (m_average_value),
        .m_last_of_frame (m_last_of_frame),
        .error_count     (error_count),
        .outstanding     (outstanding)
    );

    // Receiver: alternates ready stretches and stalls of random length. Stalls
    // are now and then long; ready stretches are long more often, so
    // back-to-back traffic is seen as well.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            m_ready    <= 1'b1;
            ready_hold <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 6);
        end else begin
            m_ready    <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    // Watchdog: any accepted item on either side resets the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL box_downsample_2x2_u8_core");
            $finish;
        end
    end

    // Sender gap before the next item: mostly none, some short, a few long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Present one source item after an optional gap and hold it until taken.
    // Returns at the edge where the item was accepted.
    task automatic send_pixel(input logic [PIX_W-1:0] value, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending, wait for every due result, then let the pipeline settle
    // (an item that yields nothing may still be in flight).
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // New geometry, then a run of random pixels. A count that is not a
    // whole number of frames leaves a partial frame for the next write to cut.
    task automatic run_geometry(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                input int count, inout int sent);
        logic gappy;
        gappy = $urandom_range(0, 3) != 0;
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        for (int i = 0; i < count; i++) begin
            send_pixel(PIX_W'($urandom_range(0, 255)), gappy ? pick_gap() : 0);
            // occasional mid-frame hold-off until the output side runs dry
            if ($urandom_range(0, 59) == 0) begin
                wait_drained();
            end
        end
        sent += count;
        wait_drained();
    endtask

    initial begin
        int sent;
        int w;
        int h;
        int frame;
        int count;
        sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sizes straight out of reset are 1x1: nothing may come out.
        send_pixel(8'd255, 0);
        send_pixel(8'd0, 0);
        wait_drained();

        // 4x2: one all-white block, one all-black block (last of frame).
        write_reg(REG_SOURCE_WIDTH, 13'd4);
        write_reg(REG_SOURCE_HEIGHT, 13'd2);
        for (int i = 0; i < 8; i++) begin
            send_pixel((i % 4 < 2) ? 8'd255 : 8'd0, pick_gap());
        end
        wait_drained();

        // Width of zero reads as one: vertical pairs, truncating average.
        write_reg(REG_SOURCE_WIDTH, 13'd0);
        write_reg(REG_SOURCE_HEIGHT, 13'd4);
        send_pixel(8'd255, 0);
        send_pixel(8'd255, 0);
        send_pixel(8'd0, 1);
        send_pixel(8'd1, 0);
        wait_drained();

        // Height of zero reads as one: horizontal pair, third column dropped.
        write_reg(REG_SOURCE_WIDTH, 13'd3);
        write_reg(REG_SOURCE_HEIGHT, 13'd0);
        send_pixel(8'd254, 0);
        send_pixel(8'd255, 0);
        send_pixel(8'd7, 0);
        wait_drained();

        // Writes to unmapped indexes mid-frame: must not restart the frame.
        send_pixel(8'd10, 0);
        wait_drained();
        write_reg(REG_SPARE_A, 13'h1FFF);
        write_reg(REG_SPARE_B, 13'h0000);
        send_pixel(8'd20, 0);
        send_pixel(8'd30, 0);
        wait_drained();

        // A real register write mid-frame restarts it.
        write_reg(REG_SOURCE_WIDTH, 13'd2);
        write_reg(REG_SOURCE_HEIGHT, 13'd2);
        send_pixel(8'd200, 0);
        send_pixel(8'd100, 0);
        send_pixel(8'd50, 0);
        wait_drained();
        write_reg(REG_SOURCE_WIDTH, 13'd2);
        for (int i = 0; i < 4; i++) begin
            send_pixel(8'(i * 60 + 3), 0);
        end
        wait_drained();

        // Random geometries, mostly small so frames close often.
        while (sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? 0
              : ($urandom_range(0, 6) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
            frame = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            count = frame * $urandom_range(1, 2) + $urandom_range(0, frame);
            if (count > RANDOM_ITEMS - sent) begin
                count = RANDOM_ITEMS - sent;
            end
            run_geometry(SIZE_W'(w), SIZE_W'(h), count, sent);
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS box_downsample_2x2_u8_core");
        end else begin
            $display("FAIL box_downsample_2x2_u8_core");
        end
        $finish;
    end

endmodule

/* box_downsample_2x2_u8_core.f */
+incdir+rtl/core
rtl/core/bds_pkg.sv
rtl/core/bds_ram.sv
rtl/core/box_downsample_2x2_u8_core.sv
dv/box_downsample_2x2_u8_core_checker.sv
dv/box_downsample_2x2_u8_core_test.sv
